// ===== design/drict_pkg.sv =====
// drict_pkg: payload structs, table entry type and controller/datapath
// command and status groups for the dns response id conflict table
// no dependencies
`default_nettype none

package drict_pkg;

  // one parsed response
  typedef struct packed {
    logic [15:0] transaction_id;
    logic [31:0] answer_address;
  } req_item_t;

  // one result
  typedef struct packed {
    logic        is_summary;
    logic [31:0] address;
    logic        poison_flag;
    logic        last;
  } rsp_item_t;

  // one table entry
  typedef struct packed {
    logic [15:0] id;
    logic [31:0] address;
  } entry_t;

  // controller to datapath
  typedef struct packed {
    logic start;    // latch new response, restart scan
    logic advance;  // scan step: read next entry, emit pending conflict
    logic finish;   // emit final result, append pair
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic hit_pending;  // registered entry matches the new id
    logic out_free;     // output register can take a result this cycle
    logic scan_done;    // every valid entry has been read and checked
  } status_t;

endpackage

`default_nettype wire

// ===== design/drict_ctrl.sv =====
// drict_ctrl: controller state machine, sequences accept, scan and final result
// depends on drict_pkg
`default_nettype none

module drict_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              req_valid,
  output logic                   req_ready,
  input  wire drict_pkg::status_t st,
  output drict_pkg::cmd_t        cmd
);
  import drict_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SCAN   = 3'b010,
    ST_FINISH = 3'b100
  } state_t;

  state_t state;
  state_t state_next;

  assign req_ready = (state == ST_IDLE);

  always_comb begin
    state_next  = state;
    cmd         = '0;
    unique case (state)
      ST_IDLE: begin
        if (req_valid) begin
          cmd.start  = 1'b1;
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (st.scan_done) begin
          state_next = ST_FINISH;
        end else begin
          // hold the scan while a matching entry waits for the output
          cmd.advance = !(st.hit_pending && !st.out_free);
        end
      end
      ST_FINISH: begin
        if (st.out_free) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // a conflict is never dropped: a pending hit with a full output holds the scan
  assert property (@(posedge clk) disable iff (rst)
    (st.hit_pending && !st.out_free) |-> !cmd.advance)
    else $error("scan advanced over a blocked conflict");

  // final result only goes out after the scan has finished
  assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> $past(state_next == ST_FINISH) && st.out_free)
    else $error("final result issued outside finish step");

  // a new response is only taken from idle
  assert property (@(posedge clk) disable iff (rst)
    cmd.start |=> (state == ST_SCAN))
    else $error("start did not enter scan");

endmodule

`default_nettype wire

// ===== design/drict_dpath.sv =====
// drict_dpath: entry memory, fill count, scan counter, id compare and
// output register
// depends on drict_pkg
`default_nettype none

module drict_dpath #(
  parameter int DEPTH = 32
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire drict_pkg::req_item_t req,
  input  wire drict_pkg::cmd_t     cmd,
  output drict_pkg::status_t       st,
  output logic                     rsp_valid,
  input  wire logic                rsp_ready,
  output drict_pkg::rsp_item_t     rsp
);
  import drict_pkg::*;

  localparam int CntW  = $clog2(DEPTH + 1);
  localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  entry_t          mem [DEPTH];
  entry_t          rd_data;
  logic            data_vld;
  logic [15:0]     id_q;
  logic [31:0]     addr_q;
  logic [CntW-1:0] n_q;
  logic [CntW-1:0] scan_idx;
  logic [CntW-1:0] fill_count;
  logic [CntW-1:0] wr_idx;
  logic            hit;
  logic            match;
  logic            rd_en;
  logic            load_out;
  rsp_item_t       out_next;

  assign match    = data_vld && (rd_data.id == id_q);
  assign rd_en    = cmd.advance && (scan_idx < n_q);
  assign wr_idx   = (n_q == CntW'(DEPTH)) ? '0 : n_q;
  assign load_out = (cmd.advance && match) || cmd.finish;

  assign st.hit_pending = match;
  assign st.out_free    = !rsp_valid || rsp_ready;
  assign st.scan_done   = !data_vld && (scan_idx == n_q);

  always_comb begin
    if (cmd.finish) begin
      out_next.is_summary  = 1'b1;
      out_next.address     = addr_q;
      out_next.poison_flag = hit;
      out_next.last        = 1'b1;
    end else begin
      out_next.is_summary  = 1'b0;
      out_next.address     = rd_data.address;
      out_next.poison_flag = 1'b0;
      out_next.last        = 1'b0;
    end
  end

  // entry memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      mem[wr_idx[AddrW-1:0]] <= '{id: id_q, address: addr_q};
    end
    if (rd_en) begin
      rd_data <= mem[scan_idx[AddrW-1:0]];
    end
  end

  // response payload
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      id_q   <= req.transaction_id;
      addr_q <= req.answer_address;
      n_q    <= fill_count;
    end
    if (load_out) begin
      rsp <= out_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      data_vld   <= 1'b0;
      scan_idx   <= '0;
      hit        <= 1'b0;
      fill_count <= '0;
      rsp_valid  <= 1'b0;
    end else begin
      if (cmd.start) begin
        data_vld <= 1'b0;
        scan_idx <= '0;
        hit      <= 1'b0;
      end else if (cmd.advance) begin
        data_vld <= rd_en;
        if (rd_en) begin
          scan_idx <= scan_idx + 1'b1;
        end
        if (match) begin
          hit <= 1'b1;
        end
      end
      // full table wraps to entry 0, so the count restarts at one
      if (cmd.finish) begin
        fill_count <= wr_idx + 1'b1;
      end
      if (load_out) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    fill_count <= CntW'(DEPTH))
    else $error("fill count beyond table depth");

  assert property (@(posedge clk) disable iff (rst)
    rd_en |-> (scan_idx < fill_count))
    else $error("read of an entry that was never written");

  assert property (@(posedge clk) disable iff (rst)
    load_out |-> st.out_free)
    else $error("output register overwritten before transfer");

  assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> rsp_valid && rsp.last && rsp.is_summary)
    else $error("final result not presented after finish");

endmodule

`default_nettype wire

// ===== design/dns_response_id_conflict_table.sv =====
// dns_response_id_conflict_table: top level, joins controller and datapath
// depends on drict_pkg, drict_ctrl, drict_dpath
//
//   channel | role   | handshake            | payload
//   --------+--------+----------------------+---------------------------------
//   req     | input  | req_valid/req_ready  | transaction_id, answer_address
//   rsp     | output | rsp_valid/rsp_ready  | is_summary, address, poison_flag,
//           |        |                      | last
//
// one response goes through these steps: take the transfer, read the n stored
// entries (n at most DEPTH) through the single read port of the entry memory,
// see the scan end, issue the final result
// while the output register stays full with a conflict or the final result
// waiting, the scan or the final result is held
// req_ready is high only while no response is in work
// reset clears the fill count and all control; memory contents stay undefined
`default_nettype none

module dns_response_id_conflict_table #(
  parameter int DEPTH = 32
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 req_valid,
  output logic                      req_ready,
  input  wire drict_pkg::req_item_t req,
  output logic                      rsp_valid,
  input  wire logic                 rsp_ready,
  output drict_pkg::rsp_item_t      rsp
);
  import drict_pkg::*;

  // command and status between controller and datapath
  cmd_t    cmd;
  status_t st;

  // sequencer: idle, scan of the stored entries, final result
  drict_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .st        (st),
    .cmd       (cmd)
  );

  // table memory, compare and output register
  drict_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd       (cmd),
    .st        (st),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

endmodule

`default_nettype wire
